@@ sv/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg: shared types for the double-ended queue
// Command and status codes, and the result flags handed from the index
// control to the output stage.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned WordW = 32;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_POP_REAR   = 2'd1,
    CMD_PUSH_FRONT = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Per-request outcome travelling with the memory read
  typedef struct packed {
    status_e status;
    logic    pop_ok;
  } res_t;

endpackage

@@ sv/double_ended_queue_core.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of 32-bit words
// Ring store in a synchronous RAM with a two-register result path.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel: tuser carries the command (push rear, pop rear, push
//   front, pop front), tdata the word to push (ignored for pops).
//   Master channel: one result per request. tdata carries the popped word
//   (zero unless a pop succeeded) and the fill count after the request;
//   tuser carries the status (ok, full on push, empty on pop).
//   A rejected push or pop leaves the queue untouched.
// Timing
//   A result passes the RAM read stage and then the output register.
//   Indices update at the accepting edge, so a request may be taken
//   every cycle; sustained rate is one request per cycle while the
//   receiver keeps up, limited by the single RAM read port.
// Reset and stalls
//   Reset empties the queue (indices and count cleared, RAM contents kept)
//   and drops any result in flight. When the receiver stalls, the output
//   register and the read stage fill, then s_axis_tready_o falls; no
//   request is lost.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned OW   = ((dq_pkg::WordW + CW + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [dq_pkg::WordW-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic [dq_pkg::CmdW-1:0]  s_axis_tuser_i,   // [1:0] cmd
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OW-1:0]            m_axis_tdata_o,   // popped, fill_count, zero pad
  output logic [dq_pkg::StatW-1:0] m_axis_tuser_o    // [1:0] status
);

  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic             accept;
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [WordW-1:0] rdata;
  res_t             res;
  logic [CW-1:0]    fill;

  logic             s1_valid_q;
  res_t             s1_res_q;
  logic [CW-1:0]    s1_fill_q;
  logic             s1_adv;

  logic             out_valid_q;
  logic [WordW-1:0] out_popped_q;
  status_e          out_status_q;
  logic [CW-1:0]    out_fill_q;

  // Handshake
  assign s1_adv          = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_e'(s_axis_tuser_i)),
    .we_o     (we),
    .waddr_o  (waddr),
    .re_o     (re),
    .raddr_o  (raddr),
    .res_o    (res),
    .fill_o   (fill)
  );

  dq_ring #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (WordW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (s_axis_tdata_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Read stage payload, alongside the RAM read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q  <= res;
      s1_fill_q <= fill;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_popped_q <= s1_res_q.pop_ok ? rdata : '0;
      out_status_q <= s1_res_q.status;
      out_fill_q   <= s1_fill_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OW - WordW - CW){1'b0}}, out_fill_q, out_popped_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

@@ sv/dq_ring.sv @@
// ----------------------------------------------------------------------------
// dq_ring: ring store
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module dq_ring #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/dq_ctrl.sv @@
// ----------------------------------------------------------------------------
// dq_ctrl: index and occupancy control
// Decodes each request, moves the front/rear indices and issues the
// ring store write or read.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned CW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  dq_pkg::cmd_e     cmd_i,
  output logic             we_o,
  output logic [AW-1:0]    waddr_o,
  output logic             re_o,
  output logic [AW-1:0]    raddr_o,
  output dq_pkg::res_t     res_o,
  output logic [CW-1:0]    fill_o
);

  import dq_pkg::*;

  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] rear_q, rear_d;
  logic [CW-1:0] occ_q, occ_d;
  logic          full, empty;

  function automatic logic [AW-1:0] step_up(input logic [AW-1:0] idx);
    return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  function automatic logic [AW-1:0] step_down(input logic [AW-1:0] idx);
    return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
  endfunction

  assign full  = (occ_q == CW'(DEPTH));
  assign empty = (occ_q == '0);

  // Request decode
  always_comb begin
    front_d       = front_q;
    rear_d        = rear_q;
    occ_d         = occ_q;
    we_o          = 1'b0;
    waddr_o       = rear_q;
    re_o          = 1'b0;
    raddr_o       = front_q;
    res_o.status  = STATUS_OK;
    res_o.pop_ok  = 1'b0;
    if (accept_i) begin
      unique case (cmd_i)
        CMD_PUSH_REAR: begin
          if (full) begin
            res_o.status = STATUS_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = rear_q;
            rear_d  = step_up(rear_q);
            occ_d   = occ_q + CW'(1);
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            res_o.status = STATUS_FULL;
          end else begin
            we_o    = 1'b1;
            waddr_o = step_down(front_q);
            front_d = step_down(front_q);
            occ_d   = occ_q + CW'(1);
          end
        end
        CMD_POP_REAR: begin
          if (empty) begin
            res_o.status = STATUS_EMPTY;
          end else begin
            re_o         = 1'b1;
            raddr_o      = step_down(rear_q);
            rear_d       = step_down(rear_q);
            res_o.pop_ok = 1'b1;
            occ_d        = occ_q - CW'(1);
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            res_o.status = STATUS_EMPTY;
          end else begin
            re_o         = 1'b1;
            raddr_o      = front_q;
            front_d      = step_up(front_q);
            res_o.pop_ok = 1'b1;
            occ_d        = occ_q - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign fill_o = occ_d;

  // Index registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      occ_q   <= '0;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
      occ_q   <= occ_d;
    end
  end

endmodule

@@ sv/dq_checker.sv @@
// ----------------------------------------------------------------------------
// dq_port_checker: port-level checks for the double-ended queue
// Watches the result channel for stall stability and consistent status.
// ----------------------------------------------------------------------------
module dq_port_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned OW   = ((dq_pkg::WordW + CW + 7) / 8) * 8
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     m_axis_tvalid_o,
  input logic                     m_axis_tready_i,
  input logic [OW-1:0]            m_axis_tdata_o,
  input logic [dq_pkg::StatW-1:0] m_axis_tuser_o
);

  import dq_pkg::*;

  logic [WordW-1:0] popped;
  logic [CW-1:0]    fill;

  assign popped = m_axis_tdata_o[WordW-1:0];
  assign fill   = m_axis_tdata_o[WordW +: CW];

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Fill never exceeds capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> fill <= CW'(DEPTH))
    else $error("fill count beyond depth");

  // Empty status: nothing held, nothing popped
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_EMPTY |-> fill == '0 && popped == '0)
    else $error("empty status inconsistent");

  // Full status: queue at capacity, nothing popped
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == STATUS_FULL |-> fill == CW'(DEPTH) && popped == '0)
    else $error("full status inconsistent");

endmodule

bind double_ended_queue_core dq_port_checker #(.DEPTH(DEPTH)) u_dq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/dq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker: result checker for the double-ended queue
// Watches both stream channels. Every accepted request is applied to a
// private copy of the queue, and the outcome is stored in order. Every
// accepted result is compared field by field with the oldest stored outcome.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned OW   = ((dq_pkg::WordW + CW + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  input  logic                     s_axis_tready_i,
  input  logic [dq_pkg::WordW-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic [dq_pkg::CmdW-1:0]  s_axis_tuser_i,   // [1:0] cmd
  input  logic                     m_axis_tvalid_i,
  input  logic                     m_axis_tready_i,
  input  logic [OW-1:0]            m_axis_tdata_i,   // popped, fill_count, zero pad
  input  logic [dq_pkg::StatW-1:0] m_axis_tuser_i,   // [1:0] status
  output int unsigned              err_cnt_o,
  output int unsigned              pending_o
);
  import dq_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] popped;
    status_e          status;
    logic [CW-1:0]    fill;
  } outcome_t;

  // Private copy of the queue
  logic [WordW-1:0] ring_q [DEPTH];
  int unsigned      front_q;
  int unsigned      rear_q;
  int unsigned      held_q;

  // Outcomes of accepted requests, oldest first
  outcome_t         awaited_q [$];

  int unsigned      err_cnt     = 0;
  int unsigned      pending_cnt = 0;

  assign err_cnt_o = err_cnt;
  assign pending_o = pending_cnt;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch, %s: got %0h, expected %0h", $time, what, got, want);
    err_cnt++;
  endtask

  // Apply one request to the copy and return what the block should answer
  function automatic outcome_t serve_request(cmd_e cmd, logic [WordW-1:0] word);
    outcome_t res;
    res.popped = '0;
    res.status = STATUS_OK;
    case (cmd)
      CMD_PUSH_REAR, CMD_PUSH_FRONT: begin
        if (held_q >= DEPTH) begin
          res.status = STATUS_FULL;
        end else if (cmd == CMD_PUSH_REAR) begin
          ring_q[rear_q] = word;
          rear_q = (rear_q + 1) % DEPTH;
          held_q++;
        end else begin
          front_q = (front_q + DEPTH - 1) % DEPTH;
          ring_q[front_q] = word;
          held_q++;
        end
      end
      default: begin
        if (held_q == 0) begin
          res.status = STATUS_EMPTY;
        end else if (cmd == CMD_POP_REAR) begin
          rear_q = (rear_q + DEPTH - 1) % DEPTH;
          res.popped = ring_q[rear_q];
          held_q--;
        end else begin
          res.popped = ring_q[front_q];
          front_q = (front_q + 1) % DEPTH;
          held_q--;
        end
      end
    endcase
    res.fill = CW'(held_q);
    return res;
  endfunction

  // Track requests and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      front_q = 0;
      rear_q  = 0;
      held_q  = 0;
      awaited_q.delete();
      pending_cnt <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        awaited_q.push_back(serve_request(cmd_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with none awaited", 64'(m_axis_tdata_i), '0);
        end else begin
          want = awaited_q.pop_front();
          if (m_axis_tdata_i[WordW-1:0] !== want.popped)
            report_mismatch("popped", 64'(m_axis_tdata_i[WordW-1:0]), 64'(want.popped));
          if (m_axis_tuser_i !== want.status)
            report_mismatch("status", 64'(m_axis_tuser_i), 64'(want.status));
          if (m_axis_tdata_i[WordW +: CW] !== want.fill)
            report_mismatch("fill count", 64'(m_axis_tdata_i[WordW +: CW]),
                            64'(want.fill));
          if ((m_axis_tdata_i >> (WordW + CW)) !== '0)
            report_mismatch("tdata padding", 64'(m_axis_tdata_i >> (WordW + CW)), '0);
        end
      end
      pending_cnt <= awaited_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the double-ended queue
// A directed opening covers both pops on an empty queue, the word extremes,
// a fill to capacity and both pushes when full. Random phases then lean
// towards filling, draining or mixing, so the queue swings between full and
// empty many times. Both sides idle at random, apart from a calm stretch.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned CW         = $clog2(DEPTH + 1);
  localparam int unsigned OW         = ((WordW + CW + 7) / 8) * 8;
  localparam int unsigned TotalItems = 700;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned CalmFrom   = 300;
  localparam int unsigned CalmTo     = 450;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [WordW-1:0] s_tdata  = '0;
  logic [CmdW-1:0]  s_tuser  = CMD_PUSH_REAR;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OW-1:0]    m_tdata;
  logic [StatW-1:0] m_tuser;

  int unsigned      sent_cnt    = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      err_cnt;
  int unsigned      pending_cnt;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  double_ended_queue_core #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  dq_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .err_cnt_o       (err_cnt),
    .pending_o       (pending_cnt)
  );

  // No idling on either side while the calm stretch of requests goes through
  function automatic bit calm_stretch();
    return (sent_cnt >= CalmFrom) && (sent_cnt < CalmTo);
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= calm_stretch() || ($urandom_range(0, 99) >= 15);
  end

  // Watchdog: too long without any request or result moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One request, after an optional random gap; returns once it is accepted
  task automatic send_request(input cmd_e cmd, input logic [WordW-1:0] word);
    while (!calm_stretch() && ($urandom_range(0, 99) < 15)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sent_cnt++;
  endtask

  initial begin
    logic [WordW-1:0] patterns [4];
    logic [WordW-1:0] word;
    cmd_e             cmd;
    int unsigned      push_pct;
    int unsigned      phase_len;
    bit               is_push;

    patterns[0] = 32'h0000_0000;
    patterns[1] = 32'hFFFF_FFFF;
    patterns[2] = 32'hAAAA_AAAA;
    patterns[3] = 32'h5555_5555;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pops on an empty queue, then the word extremes through both ends
    send_request(CMD_POP_REAR,   32'hDEAD_BEEF);
    send_request(CMD_POP_FRONT,  32'h1234_5678);
    send_request(CMD_PUSH_REAR,  32'h7FFF_FFFF);
    send_request(CMD_PUSH_FRONT, 32'h8000_0000);
    send_request(CMD_POP_REAR,   '0);
    send_request(CMD_POP_FRONT,  '0);

    // Directed: fill to capacity from both ends, then push when full
    for (int i = 0; i < DEPTH; i++) begin
      word = patterns[i % 4] ^ WordW'(i);
      send_request((i % 2) ? CMD_PUSH_FRONT : CMD_PUSH_REAR, word);
    end
    send_request(CMD_PUSH_REAR,  32'h0BAD_F00D);
    send_request(CMD_PUSH_FRONT, 32'hF00D_0BAD);

    // Random phases leaning towards filling, draining or an even mix
    while (sent_cnt < TotalItems) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      phase_len = $urandom_range(8, 48);
      repeat (phase_len) begin
        is_push = ($urandom_range(0, 99) < push_pct);
        if (is_push) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
        end else begin
          cmd = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_REAR;
        end
        case ($urandom_range(0, 9))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7FFF_FFFF;
          2:       word = '1;
          3:       word = '0;
          default: word = $urandom();
        endcase
        send_request(cmd, word);
      end
    end
    s_tvalid <= 1'b0;

    // Drain the results still in flight, then allow for the result latency
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/dq_pkg.sv
sv/dq_ring.sv
sv/dq_ctrl.sv
sv/double_ended_queue_core.sv
sv/dq_checker.sv
tb/dq_checker.sv
tb/testbench.sv
